// ===== rtl/cmpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpg_pkg
// Shared types, codes, constants and the weight table of the cosine move
// profile generator.
// ----------------------------------------------------------------------------
package cmpg_pkg;

	// tick period in ms and table resolution
	localparam int unsigned TICK_MS        = 1;
	localparam int unsigned COS_TABLE_BITS = 10;
	localparam int unsigned TAB_N          = 1 << COS_TABLE_BITS;
	localparam int unsigned IDX_W          = COS_TABLE_BITS + 1;

	// divider step counts for the table position and the interpolation
	localparam logic [4:0] Q_STEPS = 5'(COS_TABLE_BITS);
	localparam logic [4:0] W_STEPS = 5'd30;

	localparam longint          W_ONE  = 64'sd1073741824;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// signed 32-bit angle limits, in the width of the widest sum
	localparam logic signed [35:0] ANG_MAX = 36'sh07FFFFFFF;
	localparam logic signed [35:0] ANG_MIN = 36'shF80000000;

	// operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_DIVQ_GO, S_DIVQ_WAIT, S_ROM_A, S_ROM_B, S_MUL_D,
		S_DIVW_GO, S_DIVW_WAIT, S_WSUM, S_MUL_H, S_MUL_L, S_ROUND, S_FIN, S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_EXEC, CMD_DIVQ_GO, CMD_ROM_A, CMD_ROM_B, CMD_MUL_D,
		CMD_DIVW_GO, CMD_WSUM, CMD_MUL_H, CMD_MUL_L, CMD_ROUND, CMD_FIN, CMD_EMIT
	} cmd_t;

	typedef struct packed {
		logic latch;
		cmd_t step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic compute;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

	typedef logic [30:0] wtab_t [0:TAB_N];

	// one table entry: weight 0.5*(1-cos(pi*k/N)) in Q30
	function automatic logic [30:0] wtab_entry(input int unsigned k);
		longint unsigned kk;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned rp;
		longint r;
		longint v;
		logic neg;
		kk  = longint'(k);
		neg = 1'b0;
		if (2 * k > TAB_N) begin
			kk  = longint'(TAB_N - k);
			neg = 1'b1;
		end
		t  = (PI_Q30 * kk) >> COS_TABLE_BITS;
		t2 = (t * t) >> 30;
		r  = W_ONE;
		rp = (r < 0) ? 64'd0 : longint'(r);
		r  = W_ONE - longint'((t2 * rp) >> 30) / 132;
		rp = (r < 0) ? 64'd0 : longint'(r);
		r  = W_ONE - longint'((t2 * rp) >> 30) / 90;
		rp = (r < 0) ? 64'd0 : longint'(r);
		r  = W_ONE - longint'((t2 * rp) >> 30) / 56;
		rp = (r < 0) ? 64'd0 : longint'(r);
		r  = W_ONE - longint'((t2 * rp) >> 30) / 30;
		rp = (r < 0) ? 64'd0 : longint'(r);
		r  = W_ONE - longint'((t2 * rp) >> 30) / 12;
		rp = (r < 0) ? 64'd0 : longint'(r);
		r  = W_ONE - longint'((t2 * rp) >> 30) / 2;
		if (neg) begin
			r = -r;
		end
		v = W_ONE - r;
		if (v < 0) begin
			v = 0;
		end
		if (v > 2 * W_ONE) begin
			v = 2 * W_ONE;
		end
		return v[31:1];
	endfunction

	function automatic wtab_t build_wtab();
		wtab_t tab;
		for (int unsigned k = 0; k <= TAB_N; k++) begin
			tab[k] = wtab_entry(k);
		end
		return tab;
	endfunction

	localparam wtab_t WTAB = build_wtab();

	// clamp to the signed 32-bit angle range
	function automatic logic signed [31:0] sat_angle(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = v;
		if (v > ANG_MAX) begin
			r = ANG_MAX;
		end else if (v < ANG_MIN) begin
			r = ANG_MIN;
		end
		return r[31:0];
	endfunction

endpackage

// ===== rtl/cmpg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpg_div
// Restoring divider, one quotient bit per cycle, by a 16-bit divisor.
// ----------------------------------------------------------------------------
module cmpg_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] rem_init,
	input  logic [29:0] low_init,
	input  logic [4:0]  steps,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [29:0] quot,
	output logic [15:0] rem
);
	logic [15:0] rem_q;
	logic [29:0] low_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        qbit;

	// one trial subtraction per step
	always_comb begin
		trial = {rem_q, low_q[29]};
		diff  = trial - {1'b0, divisor};
		qbit  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			low_q <= low_init;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? diff[15:0] : trial[15:0];
			low_q <= {low_q[28:0], qbit};
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = low_q;
	assign rem  = rem_q;
endmodule

// ===== rtl/cmpg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpg_dp
// Move state, weight interpolation, scaling and the result register.
// ----------------------------------------------------------------------------
module cmpg_dp (
	input  cmpg_pkg::ctrl_cmd_t cmd,
	input  logic                clk,
	input  logic                arst_n,
	input  logic [47:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	output cmpg_pkg::dp_stat_t  stat,
	output logic [39:0]         m_tdata,
	output logic                m_tvalid,
	input  logic                m_tready
);
	// latched input transaction
	logic [1:0]          op_q;
	logic signed [30:0]  ang_q;
	logic                rel_q;
	logic [15:0]         dur_q;

	// move state
	logic signed [31:0]  ref_q;
	logic signed [31:0]  start_q;
	logic signed [31:0]  target_q;
	logic signed [32:0]  delta_q;
	logic [15:0]         goal_q;
	logic [15:0]         elapsed_q;
	logic                active_q;
	logic                done_q;
	logic                ign_q;

	// working registers
	logic [30:0]         wa_q;
	logic [30:0]         wb_q;
	logic [15:0]         m_q;
	logic signed [48:0]  prod_q;
	logic [31:0]         w_q;
	logic [39:0]         ph_q;
	logic [54:0]         pl_q;
	logic signed [34:0]  off_q;
	logic [39:0]         out_q;
	logic                valid_q;

	logic [15:0]         n_next;
	logic [48:0]         prod_mag;
	logic [32:0]         dmag;
	logic                div_start;
	logic                div_busy;
	logic [29:0]         div_quot;
	logic [15:0]         div_rem;
	logic [15:0]         div_rem_init;
	logic [29:0]         div_low_init;
	logic [4:0]          div_steps;
	logic [cmpg_pkg::IDX_W-1:0] idx_a;
	logic [cmpg_pkg::IDX_W-1:0] idx_b;
	logic [31:0]         qext;
	logic [55:0]         low_sum;
	logic [33:0]         res;
	logic signed [35:0]  start_sum;
	logic signed [31:0]  start_sat;
	logic signed [35:0]  fin_sum;

	// helpers
	always_comb begin
		n_next       = elapsed_q + 16'd1;
		prod_mag     = prod_q[48] ? 49'(-prod_q) : 49'(prod_q);
		dmag         = delta_q[32] ? 33'(-delta_q) : 33'(delta_q);
		div_start    = (cmd.step == cmpg_pkg::CMD_DIVQ_GO) ||
		               (cmd.step == cmpg_pkg::CMD_DIVW_GO);
		div_rem_init = (cmd.step == cmpg_pkg::CMD_DIVQ_GO) ? elapsed_q : prod_mag[45:30];
		div_low_init = (cmd.step == cmpg_pkg::CMD_DIVQ_GO) ? 30'd0 : prod_mag[29:0];
		div_steps    = (cmd.step == cmpg_pkg::CMD_DIVQ_GO) ? cmpg_pkg::Q_STEPS
		                                                   : cmpg_pkg::W_STEPS;
		idx_a        = {1'b0, div_quot[cmpg_pkg::COS_TABLE_BITS-1:0]};
		idx_b        = idx_a + 1'b1;
		qext         = {2'b00, div_quot};
		low_sum      = {26'd0, ph_q[5:0], 24'd0} + {1'b0, pl_q} + 56'h20000000;
		res          = ph_q[39:6] + {8'd0, low_sum[55:30]};
		start_sum    = rel_q ? ({{4{ref_q[31]}}, ref_q} + {{5{ang_q[30]}}, ang_q})
		                     : {{5{ang_q[30]}}, ang_q};
		start_sat    = cmpg_pkg::sat_angle(start_sum);
		fin_sum      = {{4{start_q[31]}}, start_q} + {off_q[34], off_q};
	end

	cmpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_init),
		.low_init (div_low_init),
		.steps    (div_steps),
		.divisor  (goal_q),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= s_tuser;
			ang_q <= s_tdata[30:0];
			rel_q <= s_tdata[31];
			dur_q <= s_tdata[47:32];
		end
	end

	// move state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q     <= '0;
			start_q   <= '0;
			target_q  <= '0;
			delta_q   <= '0;
			goal_q    <= '0;
			elapsed_q <= '0;
			active_q  <= 1'b0;
			done_q    <= 1'b0;
			ign_q     <= 1'b0;
		end else if (cmd.step == cmpg_pkg::CMD_EXEC) begin
			done_q <= 1'b0;
			ign_q  <= 1'b0;
			case (op_q)
				cmpg_pkg::OP_START: begin
					if (active_q) begin
						ign_q <= 1'b1;
					end else begin
						start_q   <= ref_q;
						target_q  <= start_sat;
						delta_q   <= {start_sat[31], start_sat} - {ref_q[31], ref_q};
						goal_q    <= 16'(dur_q / cmpg_pkg::TICK_MS);
						elapsed_q <= '0;
						active_q  <= 1'b1;
					end
				end
				cmpg_pkg::OP_TICK: begin
					if (active_q) begin
						elapsed_q <= n_next;
						if (goal_q <= n_next) begin
							ref_q     <= target_q;
							goal_q    <= '0;
							elapsed_q <= '0;
							active_q  <= 1'b0;
							done_q    <= 1'b1;
						end
					end
				end
				cmpg_pkg::OP_LOAD: begin
					if (!active_q) begin
						ref_q <= {ang_q[30], ang_q};
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.step == cmpg_pkg::CMD_FIN) begin
			ref_q <= cmpg_pkg::sat_angle(fin_sum);
		end
	end

	// weight and scaling pipeline
	always_ff @(posedge clk) begin
		case (cmd.step)
			cmpg_pkg::CMD_ROM_A: begin
				wa_q <= cmpg_pkg::WTAB[idx_a];
				m_q  <= div_rem;
			end
			cmpg_pkg::CMD_ROM_B: begin
				wb_q <= cmpg_pkg::WTAB[idx_b];
			end
			cmpg_pkg::CMD_MUL_D: begin
				prod_q <= (49'($signed({1'b0, wb_q})) - 49'($signed({1'b0, wa_q})))
				          * 49'($signed({1'b0, m_q}));
			end
			cmpg_pkg::CMD_WSUM: begin
				w_q <= {1'b0, wa_q} + (prod_q[48] ? 32'(-qext) : qext);
			end
			cmpg_pkg::CMD_MUL_H: begin
				ph_q <= {31'd0, dmag[32:24]} * {9'd0, w_q[30:0]};
			end
			cmpg_pkg::CMD_MUL_L: begin
				pl_q <= {31'd0, dmag[23:0]} * {24'd0, w_q[30:0]};
			end
			cmpg_pkg::CMD_ROUND: begin
				off_q <= delta_q[32] ? 35'(-{1'b0, res}) : {1'b0, res};
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.step == cmpg_pkg::CMD_EMIT) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step == cmpg_pkg::CMD_EMIT) begin
			out_q <= {5'd0, ign_q, done_q, active_q, ref_q};
		end
	end

	assign stat.compute  = (op_q == cmpg_pkg::OP_TICK) && active_q && (goal_q > n_next);
	assign stat.div_busy = div_busy;
	assign stat.out_free = !valid_q || m_tready;
	assign m_tdata       = out_q;
	assign m_tvalid      = valid_q;
endmodule

// ===== rtl/cmpg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpg_ctrl
// Sequencer stepping the datapath through one transaction at a time.
// ----------------------------------------------------------------------------
module cmpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  cmpg_pkg::dp_stat_t  stat,
	output cmpg_pkg::ctrl_cmd_t cmd
);
	cmpg_pkg::state_t state_q;
	cmpg_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmpg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		cmd.latch = 1'b0;
		cmd.step  = cmpg_pkg::CMD_NONE;
		unique case (state_q)
			cmpg_pkg::S_IDLE: begin
				s_tready  = 1'b1;
				cmd.latch = s_tvalid;
				if (s_tvalid) begin
					state_d = cmpg_pkg::S_EXEC;
				end
			end
			cmpg_pkg::S_EXEC: begin
				cmd.step = cmpg_pkg::CMD_EXEC;
				state_d  = stat.compute ? cmpg_pkg::S_DIVQ_GO : cmpg_pkg::S_EMIT;
			end
			cmpg_pkg::S_DIVQ_GO: begin
				cmd.step = cmpg_pkg::CMD_DIVQ_GO;
				state_d  = cmpg_pkg::S_DIVQ_WAIT;
			end
			cmpg_pkg::S_DIVQ_WAIT: begin
				if (!stat.div_busy) begin
					state_d = cmpg_pkg::S_ROM_A;
				end
			end
			cmpg_pkg::S_ROM_A: begin
				cmd.step = cmpg_pkg::CMD_ROM_A;
				state_d  = cmpg_pkg::S_ROM_B;
			end
			cmpg_pkg::S_ROM_B: begin
				cmd.step = cmpg_pkg::CMD_ROM_B;
				state_d  = cmpg_pkg::S_MUL_D;
			end
			cmpg_pkg::S_MUL_D: begin
				cmd.step = cmpg_pkg::CMD_MUL_D;
				state_d  = cmpg_pkg::S_DIVW_GO;
			end
			cmpg_pkg::S_DIVW_GO: begin
				cmd.step = cmpg_pkg::CMD_DIVW_GO;
				state_d  = cmpg_pkg::S_DIVW_WAIT;
			end
			cmpg_pkg::S_DIVW_WAIT: begin
				if (!stat.div_busy) begin
					state_d = cmpg_pkg::S_WSUM;
				end
			end
			cmpg_pkg::S_WSUM: begin
				cmd.step = cmpg_pkg::CMD_WSUM;
				state_d  = cmpg_pkg::S_MUL_H;
			end
			cmpg_pkg::S_MUL_H: begin
				cmd.step = cmpg_pkg::CMD_MUL_H;
				state_d  = cmpg_pkg::S_MUL_L;
			end
			cmpg_pkg::S_MUL_L: begin
				cmd.step = cmpg_pkg::CMD_MUL_L;
				state_d  = cmpg_pkg::S_ROUND;
			end
			cmpg_pkg::S_ROUND: begin
				cmd.step = cmpg_pkg::CMD_ROUND;
				state_d  = cmpg_pkg::S_FIN;
			end
			cmpg_pkg::S_FIN: begin
				cmd.step = cmpg_pkg::CMD_FIN;
				state_d  = cmpg_pkg::S_EMIT;
			end
			cmpg_pkg::S_EMIT: begin
				if (stat.out_free) begin
					cmd.step = cmpg_pkg::CMD_EMIT;
					state_d  = cmpg_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cmpg_pkg::S_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/cosine_move_profile_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_move_profile_generator
// Cosine-velocity move profile generator: start, tick and load transactions
// each return one result with the reference angle and move status.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transaction, s_tuser the operation code
//   (start, tick, load); m_* returns exactly one result per command.
//   Angles are Q16.16 degrees. A start arms a move from the held reference,
//   each tick advances it along 0.5*(1-cos) and the last tick lands exactly
//   on the target.
//   Start, load, final tick and idle tick pass from acceptance through
//   the execute and emit states to m_tvalid. A tick inside a move runs
//   through the shared restoring divider (10 steps for the table position,
//   30 steps for the interpolation, each with a go and a wait state)
//   plus the two table reads, the split delta multiply and the rounding.
//   One command is worked on at a time; s_tready is high while the
//   sequencer is idle, also while a finished result waits on m_tready.
//   A stalled receiver holds the result in the output register and the
//   next command waits there until the register frees.
//   Reset clears the reference, the move state and the output valid.
// ----------------------------------------------------------------------------
module cosine_move_profile_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // angle_value[30:0], relative_mode[31], duration_ms[47:32]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // reference_out[31:0], moving[32], move_done[33],
	                              // start_ignored[34], zero pad[39:35]
);
	cmpg_pkg::ctrl_cmd_t cmd;
	cmpg_pkg::dp_stat_t  stat;

	cmpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cmpg_dp u_dp (
		.cmd      (cmd),
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);
endmodule

// ===== rtl/cmpg_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpg_chk
// Port-level checks of the move profile generator, bound to the top level.
// ----------------------------------------------------------------------------
module cmpg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// one command at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while busy");

	// a finished move reports idle
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> !m_tdata[32])
		else $error("move done while still moving");

	// an ignored start only happens during a move
	a_ign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[32] && !m_tdata[33])
		else $error("start ignored outside a move");
endmodule

bind cosine_move_profile_generator cmpg_chk u_cmpg_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
